[rtl/core/pidc_pkg.sv]
// Shared types and constants for the fixed-point PID controller.
// Used by pidc_div, pidc_mac and pid_controller_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Field and datapath widths
  localparam int ErrW    = 17;   // target - measured, signed integer
  localparam int SumW    = 48;   // integral, signed Q40.8
  localparam int DerExtW = 48;   // derivative, sign-extended to three 16-bit chunks
  localparam int GainW   = 32;   // gains, signed Q16.16
  localparam int DtW     = 16;   // sample interval, unsigned Q8.8
  localparam int OutW    = 32;   // drive, signed Q16.16
  localparam int MulAW   = GainW + 1;
  localparam int MulBW   = ErrW;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 90;   // exact Q.32 sum of the three terms
  localparam int DivNumW = 42;   // |error delta| scaled by 2^24

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  localparam logic [DtW-1:0] TimeStepRst = 16'd256;

  // Register indexes on the configuration port
  localparam logic [1:0] RegGainP    = 2'd0;
  localparam logic [1:0] RegGainI    = 2'd1;
  localparam logic [1:0] RegGainD    = 2'd2;
  localparam logic [1:0] RegTimeStep = 2'd3;

  // Left shift applied to a partial product before it joins the sum
  typedef enum logic [2:0] {
    SH_0,
    SH_8,
    SH_16,
    SH_24,
    SH_32,
    SH_40
  } shift_e;

  // Controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic   mul_en;
    logic   acc_clr;
    logic   acc_en;
    shift_e shift;
  } mac_ctl_t;

endpackage

`default_nettype wire

[rtl/core/pidc_div.sv]
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on pidc_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module pidc_div
  import pidc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DtW-1:0]     den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [DivNumW-1:0]      quot_o
);

  localparam int DivIter = DivNumW / 2;
  localparam int CntW    = $clog2(DivIter);

  logic [DivNumW-1:0] num_q, num_d;
  logic [DtW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DtW:0] t1, t2;
  logic         ge1, ge2;
  logic [DtW-1:0] r1;

  // Two restoring steps: shift in a dividend bit, subtract where it fits
  always_comb begin
    t1    = {rem_q, num_q[DivNumW-1]};
    ge1   = (t1 >= {1'b0, den_i});
    r1    = ge1 ? DtW'(t1 - {1'b0, den_i}) : t1[DtW-1:0];
    t2    = {r1, num_q[DivNumW-2]};
    ge2   = (t2 >= {1'b0, den_i});
    rem_d = ge2 ? DtW'(t2 - {1'b0, den_i}) : t2[DtW-1:0];
    num_d = {num_q[DivNumW-3:0], ge1, ge2};
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivIter - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Hold dividend/quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

[rtl/core/pidc_mac.sv]
// Shared 33x17 signed multiplier with registered product and a shifting accumulator.
// Depends on pidc_pkg for widths, shift codes and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module pidc_mac
  import pidc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire mac_ctl_t                ctl_i,
  input  wire logic signed [MulAW-1:0] a_i,
  input  wire logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0]      prod_o,
  output logic signed [AccW-1:0]       acc_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  addend;

  // Align the partial product to its weight in the sum
  always_comb begin
    prod_ext = AccW'(prod_q);
    case (ctl_i.shift)
      SH_0:    addend = prod_ext;
      SH_8:    addend = prod_ext <<< 8;
      SH_16:   addend = prod_ext <<< 16;
      SH_24:   addend = prod_ext <<< 24;
      SH_32:   addend = prod_ext <<< 32;
      SH_40:   addend = prod_ext <<< 40;
      default: addend = prod_ext;
    endcase
  end

  // Multiply, then accumulate on a later cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + addend;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

[rtl/core/pid_controller_top.sv]
// Positional PID controller top: configuration port, step sequencer, saturation.
// Depends on pidc_pkg, pidc_div and pidc_mac.
//
// Each input beat (measured, target, restart) yields one output beat (drive,
// saturated). A beat is accepted only while the block is idle. After the accept
// cycle the block runs the derivative divider (42 quotient bits at two bits a
// cycle), then eight multiply and accumulate passes, each through ST_MUL and
// ST_ACC, on the single 33x17 multiplier, and last saturates in ST_FIN and loads
// the output register once it is free. The output waits in its register while
// the next beat is taken. Gains and time step must be written through the
// APB-style port only while idle; the block itself does not enforce this. A time
// step of zero acts as one LSB (1/256).
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_top
  import pidc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] measured_i,
  input  wire logic signed [15:0] target_i,
  input  wire logic               restart_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [OutW-1:0]  drive_o,
  output logic                    saturated_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_e;

  // Multiply pass: integral increment, then the chunks of the three terms
  typedef enum logic [2:0] {
    T_ES,
    T_P,
    T_I0,
    T_I1,
    T_I2,
    T_D0,
    T_D1,
    T_D2
  } term_e;

  // Configuration registers
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DtW-1:0]          time_step_q;
  logic [DtW-1:0]          dt_eff;

  // Sequencer and state
  state_e                  state_q;
  term_e                   term_q;
  logic signed [SumW-1:0]  error_sum_q;
  logic signed [ErrW-1:0]  last_error_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [DerExtW-1:0] deriv_q;
  logic                    deriv_neg_q;
  logic                    clip_q;
  logic                    out_valid_q;
  logic signed [OutW-1:0]  drive_q;
  logic                    sat_q;

  // Accept-cycle arithmetic
  logic                    in_fire;
  logic signed [ErrW-1:0]  err_d;
  logic signed [ErrW-1:0]  last_eff;
  logic signed [ErrW:0]    delta;
  logic [ErrW:0]           delta_mag;
  logic [DivNumW-1:0]      div_num;

  // Shared units
  logic                    div_start, div_busy, div_done;
  logic [DivNumW-1:0]      div_quot;
  logic [DerExtW-1:0]      quot_ext;
  mac_ctl_t                mac_ctl;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;

  // Integral update and output saturation
  logic signed [SumW:0]    es_sum;
  logic [AccW-OutW-16:0]   acc_hi;
  logic                    out_fits;
  logic signed [OutW-1:0]  drive_d;

  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign dt_eff = (time_step_q == '0) ? DtW'(1) : time_step_q;

  // Register read back
  always_comb begin
    case (paddr[3:2])
      RegGainP:    prdata = gain_p_q;
      RegGainI:    prdata = gain_i_q;
      RegGainD:    prdata = gain_d_q;
      RegTimeStep: prdata = {16'b0, time_step_q};
      default:     prdata = '0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      time_step_q <= TimeStepRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegGainP:    gain_p_q    <= pwdata;
        RegGainI:    gain_i_q    <= pwdata;
        RegGainD:    gain_d_q    <= pwdata;
        RegTimeStep: time_step_q <= pwdata[DtW-1:0];
        default:     ;
      endcase
    end
  end

  // Error, error delta and divider dividend at accept
  assign in_fire = in_valid_i && (state_q == ST_IDLE);
  always_comb begin
    err_d     = ErrW'(target_i) - ErrW'(measured_i);
    last_eff  = restart_i ? '0 : last_error_q;
    delta     = (ErrW + 1)'(err_d) - (ErrW + 1)'(last_eff);
    delta_mag = delta[ErrW] ? (ErrW + 1)'(-delta) : delta;
    div_num   = DivNumW'({delta_mag, 24'b0});
  end
  assign div_start = in_fire;
  assign quot_ext  = DerExtW'(div_quot);

  // Pick the multiplier operands and the product weight for each pass
  always_comb begin
    mac_ctl.shift = SH_0;
    mul_a         = MulAW'(gain_d_q);
    mul_b         = err_q;
    case (term_q)
      T_ES: begin
        mul_a = $signed(MulAW'(dt_eff));
        mul_b = err_q;
      end
      T_P: begin
        mul_a         = MulAW'(gain_p_q);
        mul_b         = err_q;
        mac_ctl.shift = SH_16;
      end
      T_I0: begin
        mul_a         = MulAW'(gain_i_q);
        mul_b         = {1'b0, error_sum_q[15:0]};
        mac_ctl.shift = SH_8;
      end
      T_I1: begin
        mul_a         = MulAW'(gain_i_q);
        mul_b         = {1'b0, error_sum_q[31:16]};
        mac_ctl.shift = SH_24;
      end
      T_I2: begin
        mul_a         = MulAW'(gain_i_q);
        mul_b         = {error_sum_q[47], error_sum_q[47:32]};
        mac_ctl.shift = SH_40;
      end
      T_D0: begin
        mul_a         = MulAW'(gain_d_q);
        mul_b         = {1'b0, deriv_q[15:0]};
        mac_ctl.shift = SH_0;
      end
      T_D1: begin
        mul_a         = MulAW'(gain_d_q);
        mul_b         = {1'b0, deriv_q[31:16]};
        mac_ctl.shift = SH_16;
      end
      T_D2: begin
        mul_a         = MulAW'(gain_d_q);
        mul_b         = {deriv_q[47], deriv_q[47:32]};
        mac_ctl.shift = SH_32;
      end
      default: ;
    endcase
    mac_ctl.mul_en  = (state_q == ST_MUL);
    mac_ctl.acc_clr = in_fire;
    mac_ctl.acc_en  = (state_q == ST_ACC) && (term_q != T_ES);
  end

  // Saturating integral sum
  assign es_sum = (SumW + 1)'(error_sum_q) + (SumW + 1)'(prod);

  // Floor to Q16.16 and clip to 32 bits
  always_comb begin
    acc_hi   = acc[AccW-1:OutW+15];
    out_fits = (&acc_hi) || !(|acc_hi);
    if (out_fits) begin
      drive_d = acc[OutW+15:16];
    end else begin
      drive_d = acc[AccW-1] ? OutMin : OutMax;
    end
  end

  pidc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_eff),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  pidc_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      term_q       <= T_ES;
      error_sum_q  <= '0;
      last_error_q <= '0;
      clip_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a new result replaces it
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (restart_i) begin
              error_sum_q <= '0;
            end
            last_error_q <= err_d;
            clip_q       <= 1'b0;
            term_q       <= T_ES;
            state_q      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (term_q == T_ES) begin
            if (es_sum[SumW] != es_sum[SumW-1]) begin
              error_sum_q <= es_sum[SumW] ? SumMin : SumMax;
              clip_q      <= 1'b1;
            end else begin
              error_sum_q <= es_sum[SumW-1:0];
            end
          end
          if (term_q == T_D2) begin
            state_q <= ST_FIN;
          end else begin
            term_q  <= term_e'(term_q + 3'd1);
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          // Load the result once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q       <= err_d;
      deriv_neg_q <= delta[ErrW];
    end
    if (state_q == ST_DIV && div_done) begin
      deriv_q <= deriv_neg_q ? -$signed(quot_ext) : $signed(quot_ext);
    end
    if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
      drive_q <= drive_d;
      sat_q   <= clip_q || !out_fits;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

  // Accepting a beat occupies the block for the following cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready right after accepting a beat");

  // The divider is only started when free
  a_div_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // The divider has finished before the result is formed
  a_div_idle_at_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !div_busy)
    else $error("divider still busy when forming the result");

  // A finished result waits while the output register is held
  a_fin_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_valid_q && out_stall_i |=> (state_q == ST_FIN))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
